// ===== hw/rtl/avld_pkg.sv =====
// Shared types, register indexes and status masks for the analog video lock detector.
// No dependencies; imported by every module of the block.
package avld_pkg;

   // configuration port widths
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_DETECT_MODE   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_START_CHANNEL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_START_FORMAT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SWITCH_COUNT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LOCK_COUNT    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_DROP_COUNT    = 3'd5;

   // detect modes
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_SCAN   = 2'd1;
   localparam logic [1:0] MODE_ACTIVE = 2'd2;

   // per-channel lock states
   localparam logic [1:0] LS_LOSS   = 2'd0;
   localparam logic [1:0] LS_SEARCH = 2'd1;
   localparam logic [1:0] LS_LOCKED = 2'd2;

   // clamp levels
   localparam logic [1:0] CLAMP_LOSS   = 2'd0;
   localparam logic [1:0] CLAMP_SEARCH = 2'd1;
   localparam logic [1:0] CLAMP_FULL   = 2'd2;

   // previous reading code meaning no reading yet
   localparam logic [1:0] PREV_NONE = 2'd2;

   // status byte masks
   localparam logic [7:0] LOSS_BIT    = 8'h80;
   localparam logic [7:0] PAL_MASK    = 8'hAC;
   localparam logic [7:0] PAL_CODE    = 8'h2C;
   localparam logic [7:0] FMT_MASK    = 8'hAE;
   localparam logic [7:0] FMT_IF_PAL  = 8'h28;
   localparam logic [7:0] FMT_IF_NTSC = 8'h2C;
   localparam logic [7:0] HLOCK_MASK  = 8'h28;
   localparam logic [7:0] VHLOCK_MASK = 8'h68;

   // reset values of the registers
   localparam logic [1:0] RST_DETECT_MODE  = MODE_SCAN;
   localparam logic [3:0] RST_SWITCH_COUNT = 4'd1;
   localparam logic [7:0] RST_LOCK_COUNT   = 8'd10;
   localparam logic [7:0] RST_DROP_COUNT   = 8'd5;

   // settings seen by the step logic
   typedef struct packed {
      logic [1:0] detect_mode;
      logic [3:0] switch_count;
      logic [7:0] lock_count;
      logic [7:0] drop_count;
   } cfg_type;

   // start register writes that reload channel and format
   typedef struct packed {
      logic load_channel;
      logic channel;
      logic load_format;
      logic format;
   } load_type;

   // one result item
   typedef struct packed {
      logic       lock_gained;
      logic [1:0] lock_state;
      logic [1:0] clamp_level;
      logic       clamp_update;
      logic       format_match;
      logic       pal_timing;
      logic       working_format;
      logic       format_switched;
      logic       channel_switched;
      logic       channel;
   } result_type;

   localparam int RESULT_W   = $bits(result_type);
   localparam int RSP_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== hw/rtl/avld_csr.sv =====
// Configuration register file of the analog video lock detector.
// Depends on avld_pkg for register indexes, reset values and the cfg and load structs.
module avld_csr import avld_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg,
   output load_type               load
);

   logic [1:0] mode_ff, mode_in;
   logic [3:0] switch_ff, switch_in;
   logic [7:0] lock_ff, lock_in;
   logic [7:0] drop_ff, drop_in;

   // decode one write transfer
   always_comb begin
      mode_in   = mode_ff;
      switch_in = switch_ff;
      lock_in   = lock_ff;
      drop_in   = drop_ff;
      load      = '0;
      load.channel = wr_data[0];
      load.format  = wr_data[0];
      if (wr_en) begin
         unique case (wr_index)
            REG_DETECT_MODE:   mode_in   = wr_data[1:0];
            REG_START_CHANNEL: load.load_channel = 1'b1;
            REG_START_FORMAT:  load.load_format  = 1'b1;
            REG_SWITCH_COUNT:  switch_in = wr_data[3:0];
            REG_LOCK_COUNT:    lock_in   = wr_data[7:0];
            REG_DROP_COUNT:    drop_in   = wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= RST_DETECT_MODE;
         switch_ff <= RST_SWITCH_COUNT;
         lock_ff   <= RST_LOCK_COUNT;
         drop_ff   <= RST_DROP_COUNT;
      end else begin
         mode_ff   <= mode_in;
         switch_ff <= switch_in;
         lock_ff   <= lock_in;
         drop_ff   <= drop_in;
      end
   end

   assign cfg.detect_mode  = mode_ff;
   assign cfg.switch_count = switch_ff;
   assign cfg.lock_count   = lock_ff;
   assign cfg.drop_count   = drop_ff;

endmodule

// ===== hw/rtl/avld_core.sv =====
// Per-reading step logic and tracking state of the analog video lock detector.
// Depends on avld_pkg; computes the result of one status byte in the accepting cycle.
module avld_core import avld_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] status,
   input  cfg_type    cfg,
   input  load_type   load,
   output result_type res
);

   logic [1:0] prev_ff, prev_in;
   logic [3:0] frc_ff, frc_in;
   logic [7:0] lrc_ff, lrc_in;
   logic       chan_ff, chan_in;
   logic       fmt_ff, fmt_in;
   logic [1:0] state_ff [2];
   logic [1:0] state_in [2];
   logic       pal_ff [2];
   logic       pal_in [2];

   logic       ch;
   logic       det_scan, det_fmt;
   logic       vloss, hl, vhl;
   logic [7:0] want;
   logic [8:0] next_run;
   logic [1:0] st_cur, st_new, clamp;
   logic       ch_sw, fmt_sw, clamp_up, gained;

   // status decode
   assign ch       = chan_ff;
   assign det_scan = (status & LOSS_BIT) == 8'h00;
   assign want     = fmt_ff ? FMT_IF_PAL : FMT_IF_NTSC;
   assign det_fmt  = (status & FMT_MASK) == want;
   assign vloss    = (status & LOSS_BIT) != 8'h00;
   assign hl       = (status & HLOCK_MASK) == HLOCK_MASK;
   assign vhl      = (status & VHLOCK_MASK) == VHLOCK_MASK;
   assign next_run = {1'b0, lrc_ff} + 9'd1;
   assign st_cur   = state_ff[ch];

   // loss / search / locked machine of the current channel
   always_comb begin
      st_new = st_cur;
      lrc_in = lrc_ff;
      gained = 1'b0;
      unique case (st_cur)
         LS_LOSS: begin
            if (hl || vhl) st_new = LS_SEARCH;
         end
         LS_SEARCH: begin
            if (vloss) begin
               lrc_in = '0;
               st_new = LS_LOSS;
            end else if (vhl) begin
               if (next_run >= {1'b0, cfg.lock_count}) begin
                  lrc_in = '0;
                  st_new = LS_LOCKED;
                  gained = 1'b1;
               end else begin
                  lrc_in = next_run[7:0];
               end
            end else begin
               lrc_in = '0;
            end
         end
         LS_LOCKED: begin
            if (vloss) begin
               lrc_in = '0;
               st_new = LS_LOSS;
            end else if (!vhl) begin
               if (next_run >= {1'b0, cfg.drop_count}) begin
                  lrc_in = '0;
                  st_new = LS_SEARCH;
               end else begin
                  lrc_in = next_run[7:0];
               end
            end else begin
               lrc_in = '0;
            end
         end
         default: ;
      endcase
   end

   // next state for one reading
   always_comb begin
      prev_in     = prev_ff;
      frc_in      = frc_ff;
      chan_in     = chan_ff;
      fmt_in      = fmt_ff;
      state_in[0] = state_ff[0];
      state_in[1] = state_ff[1];
      pal_in[0]   = pal_ff[0];
      pal_in[1]   = pal_ff[1];
      ch_sw       = 1'b0;
      fmt_sw      = 1'b0;
      clamp_up    = 1'b0;
      clamp       = CLAMP_LOSS;
      if (cfg.detect_mode == MODE_SCAN) begin
         // two equal presence readings settle the channel, then flip
         clamp_up = 1'b1;
         frc_in   = '0;
         if (prev_ff != {1'b0, det_scan}) begin
            prev_in = {1'b0, det_scan};
         end else begin
            state_in[ch] = {1'b0, det_scan};
            pal_in[ch]   = (status & PAL_MASK) == PAL_CODE;
            chan_in      = ~ch;
            ch_sw        = 1'b1;
            prev_in      = PREV_NONE;
         end
      end else if (cfg.detect_mode == MODE_ACTIVE) begin
         // count readings that show the other format
         if (prev_ff != {1'b0, det_fmt}) begin
            prev_in = {1'b0, det_fmt};
            frc_in  = '0;
         end else if (frc_ff < cfg.switch_count) begin
            frc_in = frc_ff + 4'd1;
         end
         if (det_fmt && frc_in == cfg.switch_count) begin
            fmt_in       = ~fmt_ff;
            fmt_sw       = 1'b1;
            state_in[ch] = LS_LOSS;
         end else begin
            state_in[ch] = st_new;
            clamp_up     = 1'b1;
            if (st_new == LS_SEARCH) clamp = vhl ? CLAMP_FULL : CLAMP_SEARCH;
            else                     clamp = st_new;
         end
      end
   end

   // state registers; start register writes reload channel and format
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= PREV_NONE;
         frc_ff      <= '0;
         lrc_ff      <= '0;
         chan_ff     <= 1'b0;
         fmt_ff      <= 1'b0;
         state_ff[0] <= LS_LOSS;
         state_ff[1] <= LS_LOSS;
         pal_ff[0]   <= 1'b0;
         pal_ff[1]   <= 1'b0;
      end else begin
         if (step) begin
            prev_ff     <= prev_in;
            frc_ff      <= frc_in;
            chan_ff     <= chan_in;
            fmt_ff      <= fmt_in;
            state_ff[0] <= state_in[0];
            state_ff[1] <= state_in[1];
            pal_ff[0]   <= pal_in[0];
            pal_ff[1]   <= pal_in[1];
            if (cfg.detect_mode == MODE_SCAN) lrc_ff <= '0;
            else if (cfg.detect_mode == MODE_ACTIVE && !fmt_sw) lrc_ff <= lrc_in;
         end
         if (load.load_channel) chan_ff <= load.channel;
         if (load.load_format)  fmt_ff  <= load.format;
      end
   end

   // result as seen after this reading
   assign res.channel          = chan_in;
   assign res.channel_switched = ch_sw;
   assign res.format_switched  = fmt_sw;
   assign res.working_format   = fmt_in;
   assign res.pal_timing       = pal_in[chan_in];
   assign res.format_match     = fmt_in == pal_in[chan_in];
   assign res.clamp_update     = clamp_up;
   assign res.clamp_level      = clamp;
   assign res.lock_state       = state_in[chan_in];
   // lock gain counts only when the machine actually ran
   assign res.lock_gained      = gained && (cfg.detect_mode == MODE_ACTIVE) && !fmt_sw;

endmodule

// ===== hw/rtl/analog_video_lock_detector.sv =====
// Top level of the analog video lock detector: stream ports, register file, step logic, result register.
// Depends on avld_pkg, avld_csr and avld_core.
//
//  channel  | direction | width | contents
//  req_     | in        | 8     | status_byte
//  rsp_     | out       | 16    | channel .. lock_gained, zero filled
//  csr_     | in        | 3+8   | register index, write data
//
// One status byte per cycle while req_tready is high; rsp registers each result at its transfer.
// All tracking state is updated in the accepting cycle by one level of compare/count logic.
// req_tready drops only while the rsp register is full and rsp_tready is low.
// Synchronous reset clears state and loads register defaults; csr writes are always taken.
module analog_video_lock_detector import avld_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // status_byte [7:0]
   input  logic [7:0]             req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // channel [0], channel_switched [1], format_switched [2], working_format [3],
   // pal_timing [4], format_match [5], clamp_update [6], clamp_level [8:7],
   // lock_state [10:9], lock_gained [11], zero [15:12]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   csr_valid,
   output logic                   csr_ready
);

   cfg_type    cfg;
   load_type   load;
   result_type res;
   logic       step;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   assign csr_ready  = 1'b1;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;

   avld_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg),
      .load     (load)
   );

   avld_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .status (req_tdata),
      .cfg    (cfg),
      .load   (load),
      .res    (res)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (step)            rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (step) rsp_data_ff <= res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RESULT_W){1'b0}}, rsp_data_ff};

endmodule

// ===== hw/rtl/avld_checker.sv =====
// Port-level checks of the analog video lock detector, bound to the top level.
// Depends on avld_pkg for the lock state and clamp codes.
module avld_checker import avld_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // every input transfer yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> rsp_tvalid)
      else $error("input transfer without result");

   // entering lock shows locked state and full clamp
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11] |->
         rsp_tdata[10:9] == LS_LOCKED && rsp_tdata[8:7] == CLAMP_FULL)
      else $error("lock gained without locked state");

   // a format flip drops the channel to loss and issues no clamp
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |->
         rsp_tdata[10:9] == LS_LOSS && !rsp_tdata[6] && !rsp_tdata[1])
      else $error("format flip with clamp or channel flip");

endmodule

bind analog_video_lock_detector avld_checker u_avld_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// ===== sim/avld_lock_check.sv =====
// Result checker for the analog video lock detector: tracks csr and status transfers,
// predicts each result and compares it with the rsp stream. Depends on avld_pkg.
module avld_lock_check import avld_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   output int                     pending,
   output int                     fail_count,
   output int                     checked,
   output int                     lock_gains,
   output int                     format_flips,
   output int                     channel_flips
);

   // tracked settings
   logic [1:0] mode_r;
   logic [3:0] flip_thresh;
   logic [7:0] lock_thresh;
   logic [7:0] drop_thresh;

   // tracked detector state
   logic [1:0] prev_seen;
   logic [3:0] wrong_run;
   logic [7:0] lock_run;
   logic       chan;
   logic       want_pal;
   logic [1:0] chan_lock [2];
   logic       chan_pal  [2];

   result_type predicted_reports [$];
   int         errors = 0;
   int         n_checked = 0, n_gains = 0, n_fmt = 0, n_chan = 0;

   assign fail_count    = errors;
   assign checked       = n_checked;
   assign lock_gains    = n_gains;
   assign format_flips  = n_fmt;
   assign channel_flips = n_chan;

   // predicted report for one status reading, updates the tracked state
   task automatic track_status(input logic [7:0] s, output result_type r);
      logic       ch, det, vloss, hl, vhl;
      logic       ch_sw, fmt_sw, clamp_up, gained;
      logic [1:0] clamp;
      logic [7:0] want;
      logic [8:0] next_run;
      ch       = chan;
      ch_sw    = 1'b0;
      fmt_sw   = 1'b0;
      clamp_up = 1'b0;
      clamp    = CLAMP_LOSS;
      gained   = 1'b0;
      if (mode_r == MODE_SCAN) begin
         // presence confirmed by two equal readings in a row
         det      = ((s & LOSS_BIT) == 8'h00);
         clamp_up = 1'b1;
         if (prev_seen != {1'b0, det}) begin
            prev_seen = {1'b0, det};
         end else begin
            chan_lock[ch] = {1'b0, det};
            chan_pal[ch]  = ((s & PAL_MASK) == PAL_CODE);
            chan          = ~ch;
            ch_sw         = 1'b1;
            prev_seen     = PREV_NONE;
         end
         wrong_run = '0;
         lock_run  = '0;
      end else if (mode_r == MODE_ACTIVE) begin
         // count readings that show the other format
         want = want_pal ? FMT_IF_PAL : FMT_IF_NTSC;
         det  = ((s & FMT_MASK) == want);
         if (prev_seen != {1'b0, det}) begin
            prev_seen = {1'b0, det};
            wrong_run = '0;
         end else if (wrong_run < flip_thresh) begin
            wrong_run = wrong_run + 4'd1;
         end
         if (det && wrong_run == flip_thresh) begin
            want_pal      = ~want_pal;
            fmt_sw        = 1'b1;
            chan_lock[ch] = LS_LOSS;
         end else begin
            // loss / search / locked machine
            vloss    = s[7];
            hl       = ((s & HLOCK_MASK) == HLOCK_MASK);
            vhl      = ((s & VHLOCK_MASK) == VHLOCK_MASK);
            next_run = {1'b0, lock_run} + 9'd1;
            case (chan_lock[ch])
               LS_LOSS: begin
                  if (hl || vhl) chan_lock[ch] = LS_SEARCH;
               end
               LS_SEARCH: begin
                  if (vloss) begin
                     lock_run      = '0;
                     chan_lock[ch] = LS_LOSS;
                  end else if (vhl) begin
                     if (next_run >= {1'b0, lock_thresh}) begin
                        lock_run      = '0;
                        chan_lock[ch] = LS_LOCKED;
                        gained        = 1'b1;
                     end else begin
                        lock_run = next_run[7:0];
                     end
                  end else begin
                     lock_run = '0;
                  end
               end
               LS_LOCKED: begin
                  if (vloss) begin
                     lock_run      = '0;
                     chan_lock[ch] = LS_LOSS;
                  end else if (!vhl) begin
                     if (next_run >= {1'b0, drop_thresh}) begin
                        lock_run      = '0;
                        chan_lock[ch] = LS_SEARCH;
                     end else begin
                        lock_run = next_run[7:0];
                     end
                  end else begin
                     lock_run = '0;
                  end
               end
               default: ;
            endcase
            clamp_up = 1'b1;
            clamp    = chan_lock[ch];
            if (clamp == CLAMP_SEARCH) clamp = vhl ? CLAMP_FULL : CLAMP_SEARCH;
         end
      end
      r.channel          = chan;
      r.channel_switched = ch_sw;
      r.format_switched  = fmt_sw;
      r.working_format   = want_pal;
      r.pal_timing       = chan_pal[chan];
      r.format_match     = (want_pal == chan_pal[chan]);
      r.clamp_update     = clamp_up;
      r.clamp_level      = clamp;
      r.lock_state       = chan_lock[chan];
      r.lock_gained      = gained;
   endtask

   function automatic int field_miss(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         mode_r       = RST_DETECT_MODE;
         flip_thresh  = RST_SWITCH_COUNT;
         lock_thresh  = RST_LOCK_COUNT;
         drop_thresh  = RST_DROP_COUNT;
         prev_seen    = PREV_NONE;
         wrong_run    = '0;
         lock_run     = '0;
         chan         = 1'b0;
         want_pal     = 1'b0;
         chan_lock[0] = LS_LOSS;
         chan_lock[1] = LS_LOSS;
         chan_pal[0]  = 1'b0;
         chan_pal[1]  = 1'b0;
         predicted_reports.delete();
         pending <= 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DETECT_MODE:   mode_r      = csr_data[1:0];
               REG_START_CHANNEL: chan        = csr_data[0];
               REG_START_FORMAT:  want_pal    = csr_data[0];
               REG_SWITCH_COUNT:  flip_thresh = csr_data[3:0];
               REG_LOCK_COUNT:    lock_thresh = csr_data;
               REG_DROP_COUNT:    drop_thresh = csr_data;
               default: ;
            endcase
         end
         // result transfer against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[RESULT_W-1:0]);
            if (predicted_reports.size() == 0) begin
               $error("result transfer with no prediction waiting: %h", rsp_tdata);
               errors++;
            end else begin
               want = predicted_reports.pop_front();
               errors += field_miss("channel", 8'(want.channel), 8'(got.channel));
               errors += field_miss("channel_switched", 8'(want.channel_switched),
                                    8'(got.channel_switched));
               errors += field_miss("format_switched", 8'(want.format_switched),
                                    8'(got.format_switched));
               errors += field_miss("working_format", 8'(want.working_format),
                                    8'(got.working_format));
               errors += field_miss("pal_timing", 8'(want.pal_timing),
                                    8'(got.pal_timing));
               errors += field_miss("format_match", 8'(want.format_match),
                                    8'(got.format_match));
               errors += field_miss("clamp_update", 8'(want.clamp_update),
                                    8'(got.clamp_update));
               errors += field_miss("clamp_level", 8'(want.clamp_level),
                                    8'(got.clamp_level));
               errors += field_miss("lock_state", 8'(want.lock_state),
                                    8'(got.lock_state));
               errors += field_miss("lock_gained", 8'(want.lock_gained),
                                    8'(got.lock_gained));
               errors += field_miss("zero_fill", 8'd0,
                                    8'(rsp_tdata[RSP_DATA_W-1:RESULT_W]));
               n_checked++;
            end
         end
         // status transfer
         if (req_tvalid && req_tready) begin
            track_status(req_tdata, want);
            predicted_reports.push_back(want);
            n_gains += want.lock_gained;
            n_fmt   += want.format_switched;
            n_chan  += want.channel_switched;
         end
         pending <= predicted_reports.size();
      end
   end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the analog video lock detector: clock, reset, status stimulus,
// register settings and stalls. Depends on avld_pkg, avld_lock_check and the block.
module tb;
   import avld_pkg::*;

   // mode code that behaves like idle, and register slots past the list
   localparam logic [1:0]             MODE_SPARE    = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_PAST_END  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_LAST_SLOT = 3'd7;
   // bit that keeps a lock reading off both format patterns
   localparam logic [7:0]             FMT_BREAK     = 8'h02;
   localparam int                     RANDOM_ITEMS  = 1900;

   typedef enum logic [2:0] {
      RD_LOCK, RD_HLOCK, RD_LOSS, RD_PAL_FMT, RD_NTSC_FMT, RD_NOISE
   } read_kind;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;

   int pending, fail_count, checked, lock_gains, format_flips, channel_flips;

   int   items_sent   = 0;
   int   burst_left   = 0;
   int   settings_run = 0;
   bit   steady       = 1'b0;
   logic hold_toggle  = 1'b0;
   logic hold_seen    = 1'b0;
   int   hold_left    = 0;
   logic [9:0] rx_cycle = '0;

   always #10 clock = ~clock;

   analog_video_lock_detector dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   avld_lock_check lock_check (
      .clock         (clock),
      .reset         (reset),
      .req_tdata     (req_tdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .pending       (pending),
      .fail_count    (fail_count),
      .checked       (checked),
      .lock_gains    (lock_gains),
      .format_flips  (format_flips),
      .channel_flips (channel_flips)
   );

   // receiver: long hold on request, otherwise a stall pattern chosen by the top bits of a free-running counter
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 10'd1;
      if (hold_toggle != hold_seen) begin
         hold_seen  <= hold_toggle;
         hold_left  <= 60;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (rx_cycle[9:8])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(0, 1) == 0);
            2'd2: rsp_tready <= ($urandom_range(0, 7) != 0);
            default: rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // random status byte of a given kind
   function automatic logic [7:0] status_of(read_kind k);
      logic [7:0] r;
      r = 8'($urandom);
      case (k)
         RD_LOCK:     return (r & ~LOSS_BIT) | VHLOCK_MASK | FMT_BREAK;
         RD_HLOCK:    return (r & ~(LOSS_BIT | (VHLOCK_MASK & ~HLOCK_MASK)))
                             | HLOCK_MASK | FMT_BREAK;
         RD_LOSS:     return r | LOSS_BIT;
         RD_PAL_FMT:  return (r & ~FMT_MASK) | FMT_IF_PAL;
         RD_NTSC_FMT: return (r & ~FMT_MASK) | FMT_IF_NTSC;
         default:     return r;
      endcase
   endfunction

   // register value with random bits above its width now and then
   function automatic logic [7:0] with_junk(logic [7:0] value, logic [7:0] keep);
      if ($urandom_range(0, 3) == 0) return (8'($urandom) & ~keep) | value;
      return value;
   endfunction

   // one status transfer, with bursts and gaps on the sender side
   task automatic send_status(input logic [7:0] s);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if (!steady && $urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_tdata  <= s;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_run(input read_kind k, input int n, input bit noisy);
      repeat (n) begin
         if (noisy && $urandom_range(0, 11) == 0) send_status(status_of(RD_NOISE));
         else send_status(status_of(k));
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and wait until every predicted result has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   initial begin : stimulus
      int         random_goal;
      int         segs;
      int         pick;
      logic [1:0] mode_pick;
      logic [3:0] cur_switch;
      logic [7:0] cur_lock;
      logic [7:0] cur_drop;
      read_kind   k;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // scan after reset: equal pairs, loss pair, presence change
      send_status(8'h00);
      send_status(8'h00);
      send_status(8'h2C);
      send_status(8'h2C);
      send_status(8'h80);
      send_status(8'h80);
      send_status(8'hFF);
      send_status(8'h7F);
      settle();

      // active with zero thresholds: flip, search, lock, drop, loss
      write_reg(REG_DETECT_MODE, {6'd0, MODE_ACTIVE});
      write_reg(REG_START_CHANNEL, 8'h00);
      write_reg(REG_START_FORMAT, 8'h01);
      write_reg(REG_SWITCH_COUNT, 8'h00);
      write_reg(REG_LOCK_COUNT, 8'h00);
      write_reg(REG_DROP_COUNT, 8'h00);
      end_writes();
      send_status(8'h28);
      send_status(8'h6A);
      send_status(8'h6A);
      send_status(8'h6A);
      send_status(8'h2A);
      send_status(8'hEA);
      settle();

      // idle and the spare mode code
      write_reg(REG_DETECT_MODE, {6'd0, MODE_SPARE});
      end_writes();
      send_status(8'h55);
      send_status(8'hAA);
      settle();
      write_reg(REG_DETECT_MODE, {6'd0, MODE_IDLE});
      end_writes();
      send_status(8'h68);
      settle();

      // active with upper bits in the data, top switch and drop thresholds, ignored slots
      write_reg(REG_DETECT_MODE, 8'hFE);
      write_reg(REG_SWITCH_COUNT, 8'h2F);
      write_reg(REG_LOCK_COUNT, 8'd10);
      write_reg(REG_DROP_COUNT, 8'hFF);
      write_reg(REG_PAST_END, 8'hFF);
      write_reg(REG_LAST_SLOT, 8'h5A);
      end_writes();
      repeat (6) send_status(8'h6A);
      settle();

      // lock threshold lowered below the running count
      write_reg(REG_LOCK_COUNT, 8'd3);
      end_writes();
      send_status(8'h6A);

      cur_switch  = 4'd15;
      cur_lock    = 8'd3;
      cur_drop    = 8'd255;
      random_goal = items_sent + RANDOM_ITEMS;

      // random settings, each followed by a run of readings
      while (items_sent < random_goal) begin
         settle();
         settings_run++;
         pick = $urandom_range(0, 19);
         if (pick < 12) mode_pick = MODE_ACTIVE;
         else if (pick < 17) mode_pick = MODE_SCAN;
         else if (pick < 19) mode_pick = MODE_IDLE;
         else mode_pick = MODE_SPARE;
         write_reg(REG_DETECT_MODE, with_junk({6'd0, mode_pick}, 8'h03));
         if ($urandom_range(0, 1)) write_reg(REG_START_CHANNEL, with_junk(8'($urandom_range(0, 1)), 8'h01));
         if ($urandom_range(0, 1)) write_reg(REG_START_FORMAT, with_junk(8'($urandom_range(0, 1)), 8'h01));
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 4))
               0: cur_switch = 4'd0;
               1: cur_switch = 4'd1;
               2: cur_switch = 4'd15;
               default: cur_switch = 4'($urandom_range(1, 15));
            endcase
            write_reg(REG_SWITCH_COUNT, with_junk({4'd0, cur_switch}, 8'h0F));
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 11))
               0: cur_lock = 8'd0;
               1: cur_lock = 8'd255;
               2: cur_lock = 8'd1;
               default: cur_lock = 8'($urandom_range(2, 12));
            endcase
            write_reg(REG_LOCK_COUNT, cur_lock);
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 11))
               0: cur_drop = 8'd0;
               1: cur_drop = 8'd255;
               2: cur_drop = 8'd1;
               default: cur_drop = 8'($urandom_range(2, 12));
            endcase
            write_reg(REG_DROP_COUNT, cur_drop);
         end
         if ($urandom_range(0, 5) == 0)
            write_reg($urandom_range(0, 1) ? REG_PAST_END : REG_LAST_SLOT, 8'($urandom));
         end_writes();

         // now and then the receiver holds off while the sender keeps going
         if (settings_run % 6 == 2) begin
            hold_toggle <= ~hold_toggle;
            steady = 1'b1;
         end

         if (mode_pick == MODE_ACTIVE) begin
            segs = (cur_lock > 20 || cur_drop > 20) ? 3 : $urandom_range(6, 12);
            repeat (segs) begin
               pick = $urandom_range(0, 19);
               if (pick < 8)
                  send_run(RD_LOCK, int'(cur_lock) + $urandom_range(0, 3),
                           $urandom_range(0, 3) == 0);
               else if (pick < 12)
                  send_run(RD_HLOCK, int'(cur_drop) + $urandom_range(0, 2),
                           $urandom_range(0, 3) == 0);
               else if (pick < 14)
                  send_run(RD_LOSS, $urandom_range(1, 3), 1'b0);
               else if (pick < 17)
                  send_run($urandom_range(0, 1) ? RD_PAL_FMT : RD_NTSC_FMT,
                           int'(cur_switch) + $urandom_range(1, 3), 1'b0);
               else
                  send_run(RD_NOISE, $urandom_range(1, 6), 1'b0);
            end
         end else if (mode_pick == MODE_SCAN) begin
            repeat ($urandom_range(8, 20)) begin
               pick = $urandom_range(0, 9);
               if (pick == 0) begin
                  send_run(RD_NOISE, 1, 1'b0);
               end else begin
                  if (pick < 4) k = RD_NTSC_FMT;
                  else if (pick < 6) k = RD_PAL_FMT;
                  else if (pick < 8) k = RD_LOSS;
                  else k = RD_NOISE;
                  send_run(k, 2, 1'b0);
               end
            end
         end else begin
            send_run(RD_NOISE, $urandom_range(5, 15), 1'b0);
         end
         steady = 1'b0;
      end

      settle();
      repeat (10) @(posedge clock);
      $display("sent %0d status readings over %0d random settings, %0d results checked",
               items_sent, settings_run, checked);
      $display("lock gains %0d, format flips %0d, channel flips %0d",
               lock_gains, format_flips, channel_flips);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // run limit
   initial begin : watchdog
      #10_000_000;
      $display("run timed out with %0d results outstanding", pending);
      $display("status: fail");
      $finish;
   end

endmodule
